### hw/rtl/gsga_pkg.sv
// Package for the genotype sharing Gram accumulator: commands, payload structs,
// and the struct that travels from the front end to the back end. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gsga_pkg;

  typedef enum logic [2:0] {
    CMD_LOAD   = 3'd0,
    CMD_COMMIT = 3'd1,
    CMD_PAD    = 3'd2,
    CMD_READ   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e_t;

  localparam int unsigned CFG_WIDTH = 9;
  localparam logic [7:0] MISSING_CODE = 8'd3;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] row_index;
    logic [7:0] col_index;
    logic [7:0] genotype;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] dosage_product_sum;
    logic [31:0]        present_pair_count;
  } out_word_t;

  // Back-end operations after classification.
  typedef enum logic [2:0] {
    OP_ACCUM = 3'd0,
    OP_PAD   = 3'd1,
    OP_READ  = 3'd2,
    OP_ZERO  = 3'd3,
    OP_CLEAR = 3'd4
  } op_e_t;

  typedef struct packed {
    op_e_t      op;
    logic [7:0] row;
    logic [7:0] col;
  } job_t;

endpackage
`default_nettype wire

### hw/rtl/gsga_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module gsga_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire                     clk,
  input  wire                     wr_en,
  input  wire [$clog2(DEPTH)-1:0] wr_addr,
  input  wire [WIDTH-1:0]         wr_data,
  input  wire [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]        rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

### hw/rtl/gsga_front.sv
// Front end: accepts input words, writes loads into the column buffer RAMs,
// classifies other commands into jobs for the queue. Uses gsga_pkg and gsga_ram.
`timescale 1ns / 1ps
`default_nettype none
module gsga_front #(
  parameter int unsigned MAX_INDIVIDUALS = 256
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  gsga_pkg::in_word_t in_data,
  output logic               job_valid,
  input  wire                job_ready,
  output gsga_pkg::job_t     job_data,
  input  wire                buf_busy,
  input  wire [$clog2(MAX_INDIVIDUALS)-1:0] col_addr_i,
  input  wire [$clog2(MAX_INDIVIDUALS)-1:0] col_addr_j,
  output logic [2:0]         col_entry_i,
  output logic [2:0]         col_entry_j
);
  localparam int unsigned IW = $clog2(MAX_INDIVIDUALS);

  logic row_ok, col_ok, is_load, is_job;
  logic          wipe_r;
  logic [IW-1:0] wipe_idx_r;
  logic          load_fire;
  logic          cb_wr_en;
  logic [IW-1:0] cb_wr_addr;
  logic [2:0]    cb_wr_data;

  // Rows at or above the store size are out of range.
  assign row_ok = ({24'd0, in_data.row_index} < 32'(MAX_INDIVIDUALS));
  assign col_ok = ({24'd0, in_data.col_index} < 32'(MAX_INDIVIDUALS));
  assign is_load = (in_data.command == gsga_pkg::CMD_LOAD);
  assign is_job  = (in_data.command == gsga_pkg::CMD_COMMIT) ||
                   (in_data.command == gsga_pkg::CMD_PAD) ||
                   (in_data.command == gsga_pkg::CMD_READ) ||
                   (in_data.command == gsga_pkg::CMD_CLEAR);

  // Hold loads while a job is pending so a commit sees the column it was given.
  assign in_ready  = !wipe_r && (is_job ? job_ready : !(is_load && buf_busy));
  assign job_valid = in_valid && is_job && !wipe_r;
  assign load_fire = in_valid && in_ready && is_load && row_ok;

  always_comb begin
    job_data.row = in_data.row_index;
    job_data.col = in_data.col_index;
    unique case (in_data.command)
      gsga_pkg::CMD_COMMIT: job_data.op = gsga_pkg::OP_ACCUM;
      gsga_pkg::CMD_PAD:    job_data.op = gsga_pkg::OP_PAD;
      gsga_pkg::CMD_READ:
        job_data.op = (row_ok && col_ok) ? gsga_pkg::OP_READ : gsga_pkg::OP_ZERO;
      default:              job_data.op = gsga_pkg::OP_CLEAR;
    endcase
  end

  // Column entry: present bit on top, signed dosage below.
  always_comb begin
    cb_wr_en   = wipe_r || load_fire;
    cb_wr_addr = wipe_r ? wipe_idx_r : IW'(in_data.row_index);
    cb_wr_data = 3'b000;
    if (!wipe_r && in_data.genotype < gsga_pkg::MISSING_CODE)
      cb_wr_data = {1'b1, in_data.genotype[1:0] - 2'd1};
  end

  // Zero the column buffer after reset, one row per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wipe_r     <= 1'b1;
      wipe_idx_r <= '0;
    end else if (wipe_r) begin
      wipe_idx_r <= wipe_idx_r + 1'b1;
      if (wipe_idx_r == IW'(MAX_INDIVIDUALS - 1)) wipe_r <= 1'b0;
    end
  end

  gsga_ram #(.WIDTH(3), .DEPTH(MAX_INDIVIDUALS)) u_col_i (
    .clk, .wr_en(cb_wr_en), .wr_addr(cb_wr_addr), .wr_data(cb_wr_data),
    .rd_addr(col_addr_i), .rd_data(col_entry_i));
  gsga_ram #(.WIDTH(3), .DEPTH(MAX_INDIVIDUALS)) u_col_j (
    .clk, .wr_en(cb_wr_en), .wr_addr(cb_wr_addr), .wr_data(cb_wr_data),
    .rd_addr(col_addr_j), .rd_data(col_entry_j));
endmodule
`default_nettype wire

### hw/rtl/gsga_queue.sv
// Two-entry job queue between front end and back end. Uses gsga_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gsga_queue (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             wr_valid,
  output logic            wr_ready,
  input  gsga_pkg::job_t  wr_data,
  output logic            rd_valid,
  input  wire             rd_ready,
  output gsga_pkg::job_t  rd_data
);
  gsga_pkg::job_t slot_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic wp_r, rp_r, push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = slot_r[rp_r];
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= wr_data;
  end
endmodule
`default_nettype wire

### hw/rtl/gsga_back.sv
// Back end: sweeps the pair stores for commit, pad and clear, serves reads,
// and runs the clearing pass after reset. Uses gsga_pkg and gsga_ram.
`timescale 1ns / 1ps
`default_nettype none
module gsga_back #(
  parameter int unsigned MAX_INDIVIDUALS = 256,
  parameter int unsigned SUM_WIDTH = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire [gsga_pkg::CFG_WIDTH-1:0] num_ind,
  input  wire                          job_valid,
  output logic                         job_ready,
  input  gsga_pkg::job_t               job_data,
  output logic [$clog2(MAX_INDIVIDUALS)-1:0] col_addr_i,
  output logic [$clog2(MAX_INDIVIDUALS)-1:0] col_addr_j,
  input  wire [2:0]                    col_entry_i,
  input  wire [2:0]                    col_entry_j,
  output logic                         out_valid,
  input  wire                          out_ready,
  output gsga_pkg::out_word_t          out_data
);
  localparam int unsigned IW = $clog2(MAX_INDIVIDUALS);
  localparam int unsigned AW = 2 * IW;
  localparam int unsigned DEPTH = MAX_INDIVIDUALS * MAX_INDIVIDUALS;
  localparam logic signed [SUM_WIDTH-1:0] SMAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SMIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
  localparam logic [SUM_WIDTH-1:0] CMAX = '1;

  typedef enum logic [2:0] {
    ST_WIPE, ST_IDLE, ST_SWEEP, ST_DRAIN, ST_RDWAIT, ST_RDOUT
  } state_t;

  state_t state_r;
  gsga_pkg::op_e_t op_r;
  logic [IW:0] i_r, j_r;          // current sweep pair, one bit wider for the end
  logic [IW:0] n_r;
  logic        p_valid_r;         // read issued last cycle for pair p_*
  logic [IW-1:0] p_i_r, p_j_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [SUM_WIDTH-1:0] s_rd, c_rd, s_wr, c_wr;
  logic [IW:0] n_eff;
  logic last_pair;

  assign n_eff = ({23'd0, num_ind} > 32'(MAX_INDIVIDUALS)) ?
                 (IW+1)'(MAX_INDIVIDUALS) : (IW+1)'(num_ind);

  gsga_ram #(.WIDTH(SUM_WIDTH), .DEPTH(DEPTH)) u_sum (
    .clk, .wr_en, .wr_addr, .wr_data(s_wr), .rd_addr, .rd_data(s_rd));
  gsga_ram #(.WIDTH(SUM_WIDTH), .DEPTH(DEPTH)) u_cnt (
    .clk, .wr_en, .wr_addr, .wr_data(c_wr), .rd_addr, .rd_data(c_rd));

  always_comb begin
    if (state_r == ST_IDLE) rd_addr = {IW'(job_data.row), IW'(job_data.col)};
    else                    rd_addr = {i_r[IW-1:0], j_r[IW-1:0]};
  end

  // Column entries come back registered, in step with the store reads.
  assign col_addr_i = i_r[IW-1:0];
  assign col_addr_j = j_r[IW-1:0];

  assign last_pair = (j_r + 1'b1 == n_r) && (i_r + 1'b1 == n_r);

  // Write-back side of the read-modify-write sweep, and the zeroing writes of the reset pass.
  logic signed [1:0] di, dj;
  logic signed [3:0] prod;
  logic both;
  always_comb begin
    di = col_entry_i[1:0];
    dj = col_entry_j[1:0];
    prod = 4'(di) * 4'(dj);
    both = col_entry_i[2] & col_entry_j[2];
    wr_addr = {p_i_r, p_j_r};
    s_wr = s_rd;
    c_wr = c_rd;
    wr_en = 1'b0;
    if (state_r == ST_WIPE) begin
      wr_en = 1'b1;
      wr_addr = {i_r[IW-1:0], j_r[IW-1:0]};
      s_wr = '0;
      c_wr = '0;
    end else if (p_valid_r) begin
      wr_en = 1'b1;
      if (op_r == gsga_pkg::OP_CLEAR) begin
        s_wr = '0;
        c_wr = '0;
      end else begin
        if (op_r == gsga_pkg::OP_PAD || prod > 0) begin
          if ($signed(s_rd) != SMAX) s_wr = s_rd + 1'b1;
        end else if (prod < 0) begin
          if ($signed(s_rd) != SMIN) s_wr = s_rd - 1'b1;
        end
        if (op_r == gsga_pkg::OP_ACCUM && both && c_rd != CMAX) c_wr = c_rd + 1'b1;
      end
    end
  end

  assign job_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_WIPE;
      i_r       <= '0;
      j_r       <= '0;
      p_valid_r <= 1'b0;
      out_valid <= 1'b0;
      op_r      <= gsga_pkg::OP_CLEAR;
      n_r       <= '0;
    end else begin
      p_valid_r <= 1'b0;
      unique case (state_r)
        ST_WIPE: begin
          if (j_r[IW-1:0] == '1) begin
            j_r <= '0;
            if (i_r[IW-1:0] == '1) begin
              i_r <= '0;
              state_r <= ST_IDLE;
            end else i_r <= i_r + 1'b1;
          end else j_r <= j_r + 1'b1;
        end
        ST_IDLE: begin
          if (job_valid) begin
            op_r <= job_data.op;
            i_r <= '0;
            j_r <= '0;
            priority case (job_data.op)
              gsga_pkg::OP_READ: state_r <= ST_RDWAIT;
              gsga_pkg::OP_ZERO: begin
                out_data  <= '0;
                out_valid <= 1'b1;
                state_r   <= ST_RDOUT;
              end
              gsga_pkg::OP_CLEAR: begin
                n_r <= (IW+1)'(MAX_INDIVIDUALS);
                state_r <= ST_SWEEP;
              end
              default: begin
                n_r <= n_eff;
                state_r <= (n_eff == '0) ? ST_IDLE : ST_SWEEP;
              end
            endcase
          end
        end
        ST_SWEEP: begin
          p_valid_r <= 1'b1;
          p_i_r <= i_r[IW-1:0];
          p_j_r <= j_r[IW-1:0];
          if (last_pair) state_r <= ST_DRAIN;
          else if (j_r + 1'b1 == n_r) begin
            j_r <= '0;
            i_r <= i_r + 1'b1;
          end else j_r <= j_r + 1'b1;
        end
        ST_DRAIN: state_r <= ST_IDLE;
        ST_RDWAIT: begin
          out_data.dosage_product_sum <= 32'($signed(s_rd));
          out_data.present_pair_count <= 32'(c_rd);
          out_valid <= 1'b1;
          state_r   <= ST_RDOUT;
        end
        ST_RDOUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state_r   <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### hw/rtl/genotype_sharing_gram_accumulator_core.sv
// Genotype sharing Gram accumulator, top level. Uses gsga_pkg and its three parts.
// Loads are held while a job is queued or the back end is busy.
// Commit and pad sweep the n*n pairs, one pair per cycle (none when n is 0); clear sweeps
// all MAX_INDIVIDUALS^2 pairs; a read gives its word registered from the pair stores.
// Reset: the column buffer clears row by row (input held meanwhile) and both pair
// stores clear pair by pair (jobs and loads wait for it).
`timescale 1ns / 1ps
`default_nettype none
module genotype_sharing_gram_accumulator_core #(
  parameter int unsigned MAX_INDIVIDUALS = 256,
  parameter int unsigned SUM_WIDTH = 32
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  gsga_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output gsga_pkg::out_word_t out_data,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire [gsga_pkg::CFG_WIDTH-1:0] cfg_data
);
  // Hold the individual count; always take a write.
  logic [gsga_pkg::CFG_WIDTH-1:0] num_ind_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) num_ind_r <= gsga_pkg::CFG_WIDTH'(256);
    else if (cfg_valid) num_ind_r <= cfg_data;
  end

  logic fq_valid, fq_ready, qb_valid, qb_ready;
  gsga_pkg::job_t fq_data, qb_data;
  logic [$clog2(MAX_INDIVIDUALS)-1:0] col_addr_i, col_addr_j;
  logic [2:0] col_entry_i, col_entry_j;
  logic buf_busy;

  // A queued job or a busy back end still needs the column as it stands.
  assign buf_busy = qb_valid || !qb_ready;

  gsga_front #(.MAX_INDIVIDUALS(MAX_INDIVIDUALS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .job_valid(fq_valid), .job_ready(fq_ready), .job_data(fq_data),
    .buf_busy, .col_addr_i, .col_addr_j, .col_entry_i, .col_entry_j);

  gsga_queue u_queue (
    .clk, .rst_n, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data));

  gsga_back #(.MAX_INDIVIDUALS(MAX_INDIVIDUALS), .SUM_WIDTH(SUM_WIDTH)) u_back (
    .clk, .rst_n, .num_ind(num_ind_r),
    .job_valid(qb_valid), .job_ready(qb_ready), .job_data(qb_data),
    .col_addr_i, .col_addr_j, .col_entry_i, .col_entry_j,
    .out_valid, .out_ready, .out_data);
endmodule
`default_nettype wire
